// ----- design/cbs_pkg.sv -----
// Shared constants, types and state encoding for the category blend smoother.
`default_nettype none

package cbs_pkg;

	localparam int MAX_PARAMS     = 16;
	localparam int NUM_CATEGORIES = 9;

	localparam int SLOT_W     = $clog2(MAX_PARAMS);
	localparam int CAT_W      = 4;
	localparam int FIELD_W    = 4;
	localparam int VALUE_W    = 16;
	localparam int COUNT_W    = 5;
	localparam int CAT_DEPTH  = MAX_PARAMS * NUM_CATEGORIES;
	localparam int CAT_ADDR_W = $clog2(CAT_DEPTH);

	localparam logic [FIELD_W-1:0] FIELD_SPEED  = FIELD_W'(NUM_CATEGORIES);
	localparam logic [FIELD_W-1:0] FIELD_LOWER  = FIELD_W'(NUM_CATEGORIES + 1);
	localparam logic [FIELD_W-1:0] FIELD_UPPER  = FIELD_W'(NUM_CATEGORIES + 2);
	localparam logic [FIELD_W-1:0] FIELD_SMOOTH = FIELD_W'(NUM_CATEGORIES + 3);

	localparam logic MODE_TICK  = 1'b0;
	localparam logic MODE_WRITE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} cbs_state_t;

	typedef struct packed {
		logic              tick_start;
		logic              write_en;
		logic              issue;
		logic [SLOT_W-1:0] slot;
		logic              last;
	} cbs_cmd_t;

	typedef struct packed {
		logic advance;
		logic busy;
	} cbs_sts_t;

endpackage

`default_nettype wire

// ----- design/category_blend_smoother.sv -----
// Top level of the category blend smoother: controller, datapath and ports.
`default_nettype none

// A write word stores one setting of one parameter. A tick word walks the active parameters
// in slot order, issuing one parameter per cycle unless the output stalls, into a seven-stage
// blend and smoothing pipeline, and gives one result word per parameter, the last one flagged.
// With N active parameters, N at least one, the input stays not ready after a tick word while
// the parameters are issued and until the last one has left the pipeline for the output
// register. A tick with no active parameter gives no result and leaves the input ready, as a
// write does. A stalled output holds the whole pipeline and the tick with it.
// The active count is written through the configuration channel, which is always ready.
module category_blend_smoother
	import cbs_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic                      mode,
	input  wire logic [SLOT_W-1:0]         param_slot,
	input  wire logic [FIELD_W-1:0]        setting_field,
	input  wire logic signed [VALUE_W-1:0] setting_value,
	input  wire logic [CAT_W-1:0]          current_category,
	input  wire logic [CAT_W-1:0]          previous_category,
	input  wire logic [15:0]               transition_pct,
	input  wire logic [15:0]               delta_time,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [SLOT_W-1:0]              out_slot,
	output logic signed [VALUE_W-1:0]      smoothed_value,
	output logic signed [VALUE_W-1:0]      blend_target,
	output logic                           last_of_tick,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [COUNT_W-1:0]        cfg_data
);

	cbs_cmd_t cmd;
	cbs_sts_t sts;

	cbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.sts       (sts),
		.cmd       (cmd)
	);

	cbs_datapath u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.param_slot        (param_slot),
		.setting_field     (setting_field),
		.setting_value     (setting_value),
		.current_category  (current_category),
		.previous_category (previous_category),
		.transition_pct    (transition_pct),
		.delta_time        (delta_time),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.out_slot          (out_slot),
		.smoothed_value    (smoothed_value),
		.blend_target      (blend_target),
		.last_of_tick      (last_of_tick)
	);

endmodule

`default_nettype wire

// ----- design/cbs_ctrl.sv -----
// Controller state machine that sequences the parameter walk of each tick.
`default_nettype none

module cbs_ctrl
	import cbs_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               mode,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [COUNT_W-1:0] cfg_data,
	input  wire cbs_sts_t           sts,
	output cbs_cmd_t                cmd
);

	cbs_state_t         state_q, state_d;
	logic [SLOT_W-1:0]  idx_q, idx_d;
	logic [COUNT_W-1:0] active_q;
	logic [COUNT_W-1:0] count;
	logic               in_acc;

	assign cfg_ready = 1'b1;
	assign count     = (active_q > COUNT_W'(MAX_PARAMS)) ? COUNT_W'(MAX_PARAMS) : active_q;
	assign in_acc    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			idx_q    <= '0;
			active_q <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (cfg_valid && cfg_ready) begin
				active_q <= cfg_data;
			end
		end
	end

	always_comb begin
		state_d        = state_q;
		idx_d          = idx_q;
		in_ready       = 1'b0;
		cmd.tick_start = 1'b0;
		cmd.write_en   = 1'b0;
		cmd.issue      = 1'b0;
		cmd.slot       = idx_q;
		cmd.last       = ((COUNT_W'(idx_q) + COUNT_W'(1)) == count);
		unique case (state_q)
			ST_IDLE: begin
				in_ready       = 1'b1;
				cmd.tick_start = in_acc && (mode == MODE_TICK);
				cmd.write_en   = in_acc && (mode == MODE_WRITE);
				idx_d          = '0;
				if (cmd.tick_start && (count != '0)) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.issue = 1'b1;
				if (sts.advance) begin
					if (cmd.last) begin
						state_d = ST_DRAIN;
					end else begin
						idx_d = idx_q + SLOT_W'(1);
					end
				end
			end
			ST_DRAIN: begin
				if (!sts.busy) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- design/cbs_datapath.sv -----
// Datapath with the setting stores, the blend and smoothing pipeline and the output register.
`default_nettype none

module cbs_datapath
	import cbs_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire cbs_cmd_t                  cmd,
	output cbs_sts_t                       sts,
	input  wire logic [SLOT_W-1:0]         param_slot,
	input  wire logic [FIELD_W-1:0]        setting_field,
	input  wire logic signed [VALUE_W-1:0] setting_value,
	input  wire logic [CAT_W-1:0]          current_category,
	input  wire logic [CAT_W-1:0]          previous_category,
	input  wire logic [15:0]               transition_pct,
	input  wire logic [15:0]               delta_time,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [SLOT_W-1:0]              out_slot,
	output logic signed [VALUE_W-1:0]      smoothed_value,
	output logic signed [VALUE_W-1:0]      blend_target,
	output logic                           last_of_tick
);

	logic signed [VALUE_W-1:0] cat_mem [CAT_DEPTH];
	logic signed [VALUE_W-1:0] speed_mem [MAX_PARAMS];
	logic signed [VALUE_W-1:0] lower_mem [MAX_PARAMS];
	logic signed [VALUE_W-1:0] upper_mem [MAX_PARAMS];
	logic [MAX_PARAMS-1:0]     smooth_q;
	logic signed [VALUE_W-1:0] running_q [MAX_PARAMS];

	logic [15:0]      pct_q;
	logic [16:0]      k_q;
	logic [CAT_W-1:0] cur_cat_q, prev_cat_q;
	logic [CAT_W-1:0] cur_cat_d, prev_cat_d;
	logic [16:0]      k_raw;

	logic                  advance;
	logic                  cat_we;
	logic [CAT_ADDR_W-1:0] cat_waddr, addr_a, addr_b;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic [SLOT_W-1:0] slot_s1, slot_s2, slot_s3, slot_s4, slot_s5, slot_s6, slot_s7;
	logic last_s1, last_s2, last_s3, last_s4, last_s5, last_s6, last_s7;
	logic smooth_s1, smooth_s2, smooth_s3, smooth_s4;
	logic signed [VALUE_W-1:0] a_s1, a_s2, a_s3, a_s4, a_s5;
	logic signed [VALUE_W-1:0] b_s1, speed_s1;
	logic signed [VALUE_W-1:0] lo_s1, lo_s2, lo_s3, lo_s4, lo_s5, lo_s6, lo_s7;
	logic signed [VALUE_W-1:0] hi_s1, hi_s2, hi_s3, hi_s4, hi_s5, hi_s6, hi_s7;
	logic signed [16:0] diff_s2, diff_s3, diff_s4;
	logic [30:0] prod_s2;
	logic [15:0] t_s3, t_s4;
	logic [31:0] tt_s3;
	logic [30:0] sr_s4;
	logic signed [33:0] bprod_s5;
	logic signed [VALUE_W-1:0] target_s6, target_s7;
	logic signed [VALUE_W-1:0] cur_s6, cur_s7;
	logic signed [35:0] cprod_s7;

	logic [14:0]               spd;
	logic signed [16:0]        diff_d;
	logic [30:0]               prod_d;
	logic [15:0]               t_d;
	logic [31:0]               tt_d;
	logic [15:0]               t2;
	logic [16:0]               w;
	logic [30:0]               sr_d;
	logic [15:0]               s;
	logic signed [33:0]        bprod_d;
	logic signed [19:0]        tsum;
	logic signed [17:0]        d2;
	logic signed [35:0]        cprod_d;
	logic signed [20:0]        csum, clo, chi;
	logic signed [VALUE_W-1:0] result;

	logic out_valid_q;

	assign advance     = !out_valid_q || out_ready;
	assign sts.advance = advance;
	assign sts.busy    = valid_s1 || valid_s2 || valid_s3 || valid_s4 ||
	                     valid_s5 || valid_s6 || valid_s7;

	assign cur_cat_d  = (current_category >= CAT_W'(NUM_CATEGORIES)) ?
	                    CAT_W'(NUM_CATEGORIES - 1) : current_category;
	assign prev_cat_d = (previous_category >= CAT_W'(NUM_CATEGORIES)) ?
	                    CAT_W'(NUM_CATEGORIES - 1) : previous_category;
	assign k_raw      = {delta_time, 1'b0};

	assign cat_we    = cmd.write_en && (setting_field < FIELD_W'(NUM_CATEGORIES));
	assign cat_waddr = CAT_ADDR_W'(param_slot) * CAT_ADDR_W'(NUM_CATEGORIES) +
	                   CAT_ADDR_W'(setting_field);
	assign addr_a    = CAT_ADDR_W'(cmd.slot) * CAT_ADDR_W'(NUM_CATEGORIES) +
	                   CAT_ADDR_W'(prev_cat_q);
	assign addr_b    = CAT_ADDR_W'(cmd.slot) * CAT_ADDR_W'(NUM_CATEGORIES) +
	                   CAT_ADDR_W'(cur_cat_q);

	always_ff @(posedge clk) begin
		if (cmd.tick_start) begin
			pct_q      <= transition_pct;
			k_q        <= (k_raw > 17'd65536) ? 17'd65536 : k_raw;
			cur_cat_q  <= cur_cat_d;
			prev_cat_q <= prev_cat_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cat_we) begin
			cat_mem[cat_waddr] <= setting_value;
		end
		if (advance) begin
			a_s1 <= cat_mem[addr_a];
			b_s1 <= cat_mem[addr_b];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write_en && (setting_field == FIELD_SPEED)) begin
			speed_mem[param_slot] <= setting_value;
		end
		if (cmd.write_en && (setting_field == FIELD_LOWER)) begin
			lower_mem[param_slot] <= setting_value;
		end
		if (cmd.write_en && (setting_field == FIELD_UPPER)) begin
			upper_mem[param_slot] <= setting_value;
		end
		if (advance) begin
			speed_s1 <= speed_mem[cmd.slot];
			lo_s1    <= lower_mem[cmd.slot];
			hi_s1    <= upper_mem[cmd.slot];
		end
	end

	// Stage arithmetic.
	assign spd     = speed_s1[15] ? 15'd0 : speed_s1[14:0];
	assign prod_d  = 31'(pct_q) * 31'(spd);
	assign diff_d  = {b_s1[15], b_s1} - {a_s1[15], a_s1};
	assign t_d     = (prod_s2[30:8] > 23'd32768) ? 16'd32768 : prod_s2[23:8];
	assign tt_d    = 32'(t_d) * 32'(t_d);
	assign t2      = tt_s3[30:15];
	assign w       = 17'd98304 - {t_s3, 1'b0};
	assign sr_d    = 31'(t2) * 31'(w);
	assign s       = smooth_s4 ? sr_s4[30:15] : t_s4;
	assign bprod_d = 34'(diff_s4) * 34'($signed({1'b0, s}));
	assign tsum    = 20'(a_s5) + 20'(bprod_s5 >>> 15);
	assign d2      = 18'(target_s6) - 18'(cur_s6);
	assign cprod_d = 36'(d2) * 36'($signed({1'b0, k_q}));
	assign csum    = 21'(cur_s7) + 21'(cprod_s7 >>> 16);
	assign clo     = 21'(lo_s7);
	assign chi     = 21'(hi_s7);

	always_comb begin
		result = csum[15:0];
		if (csum < clo) begin
			result = lo_s7;
		end
		if ((csum < clo ? clo : csum) > chi) begin
			result = hi_s7;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			valid_s5    <= 1'b0;
			valid_s6    <= 1'b0;
			valid_s7    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= cmd.issue;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			valid_s5    <= valid_s4;
			valid_s6    <= valid_s5;
			valid_s7    <= valid_s6;
			out_valid_q <= valid_s7;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q <= '0;
			for (int i = 0; i < MAX_PARAMS; i++) begin
				running_q[i] <= '0;
			end
		end else begin
			if (cmd.write_en && (setting_field == FIELD_SMOOTH)) begin
				smooth_q[param_slot] <= (setting_value != '0);
			end
			if (advance && valid_s7) begin
				running_q[slot_s7] <= result;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			slot_s1   <= cmd.slot;
			last_s1   <= cmd.last;
			smooth_s1 <= smooth_q[cmd.slot];

			slot_s2   <= slot_s1;
			last_s2   <= last_s1;
			smooth_s2 <= smooth_s1;
			a_s2      <= a_s1;
			lo_s2     <= lo_s1;
			hi_s2     <= hi_s1;
			diff_s2   <= diff_d;
			prod_s2   <= prod_d;

			slot_s3   <= slot_s2;
			last_s3   <= last_s2;
			smooth_s3 <= smooth_s2;
			a_s3      <= a_s2;
			lo_s3     <= lo_s2;
			hi_s3     <= hi_s2;
			diff_s3   <= diff_s2;
			t_s3      <= t_d;
			tt_s3     <= tt_d;

			slot_s4   <= slot_s3;
			last_s4   <= last_s3;
			smooth_s4 <= smooth_s3;
			a_s4      <= a_s3;
			lo_s4     <= lo_s3;
			hi_s4     <= hi_s3;
			diff_s4   <= diff_s3;
			t_s4      <= t_s3;
			sr_s4     <= sr_d;

			slot_s5   <= slot_s4;
			last_s5   <= last_s4;
			a_s5      <= a_s4;
			lo_s5     <= lo_s4;
			hi_s5     <= hi_s4;
			bprod_s5  <= bprod_d;

			slot_s6   <= slot_s5;
			last_s6   <= last_s5;
			lo_s6     <= lo_s5;
			hi_s6     <= hi_s5;
			target_s6 <= tsum[15:0];
			cur_s6    <= running_q[slot_s5];

			slot_s7   <= slot_s6;
			last_s7   <= last_s6;
			lo_s7     <= lo_s6;
			hi_s7     <= hi_s6;
			target_s7 <= target_s6;
			cur_s7    <= cur_s6;
			cprod_s7  <= cprod_d;

			out_slot       <= slot_s7;
			last_of_tick   <= last_s7;
			smoothed_value <= result;
			blend_target   <= target_s7;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ----- design/cbs_checker.sv -----
// Port-level checker for the category blend smoother and its bind statement.
`default_nettype none

module cbs_checker
	import cbs_pkg::*;
(
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      in_valid,
	input wire logic                      in_ready,
	input wire logic                      mode,
	input wire logic                      out_valid,
	input wire logic                      out_ready,
	input wire logic [SLOT_W-1:0]         out_slot,
	input wire logic signed [VALUE_W-1:0] smoothed_value,
	input wire logic signed [VALUE_W-1:0] blend_target,
	input wire logic                      last_of_tick,
	input wire logic                      cfg_valid,
	input wire logic                      cfg_ready,
	input wire logic [COUNT_W-1:0]        cfg_data
);

	logic [COUNT_W-1:0] active_q;
	logic [SLOT_W-1:0]  exp_slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= '0;
			exp_slot_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				active_q <= cfg_data;
			end
			if (out_valid && out_ready) begin
				exp_slot_q <= last_of_tick ? '0 : exp_slot_q + SLOT_W'(1);
			end
		end
	end

	// A setting write leaves the block ready in the next cycle.
	a_write_keeps_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (mode == MODE_WRITE) |=> in_ready)
		else $error("input not ready after a setting write");

	// A tick with active parameters occupies the block.
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (mode == MODE_TICK) && (active_q != '0) |=> !in_ready)
		else $error("input still ready after starting a tick");

	// Results of a tick come out in slot order starting from slot zero.
	a_slot_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_slot == exp_slot_q))
		else $error("result word out of slot order");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_slot) &&
		$stable(smoothed_value) && $stable(blend_target) && $stable(last_of_tick))
		else $error("stalled result word changed");

endmodule

bind category_blend_smoother cbs_checker u_cbs_checker (.*);

`default_nettype wire

// ----- bench/category_blend_smoother_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the category blend smoother: a directed table, then random phases.
module category_blend_smoother_tb;
	import cbs_pkg::*;

	localparam int VALUES_PER_SLOT = NUM_CATEGORIES + 3;
	localparam int SETTLE_CYCLES = MAX_PARAMS + 12;
	localparam longint ONE_Q15 = 32768;
	localparam longint ONE_Q16 = 65536;
	localparam logic [FIELD_W-1:0] FIELD_UNUSED = FIELD_SMOOTH + 1'b1;
	localparam int SIDE_SEND = 0;
	localparam int SIDE_TAKE = 1;
	localparam int PHASES = 7;

	typedef enum logic [0:0] {ROW_WORD, ROW_CFG} row_kind_t;
	typedef enum logic [1:0] {CHECK_MODEL, CHECK_NONE, CHECK_ONE} check_t;

	typedef struct packed {
		logic mode;
		logic [SLOT_W-1:0] slot;
		logic [FIELD_W-1:0] field;
		logic [VALUE_W-1:0] value;
		logic [CAT_W-1:0] cur;
		logic [CAT_W-1:0] prev;
		logic [15:0] pct;
		logic [15:0] dt;
	} in_word_t;

	typedef struct packed {
		row_kind_t kind;
		in_word_t w;
		check_t how;
		logic [VALUE_W-1:0] exp_smooth;
		logic [VALUE_W-1:0] exp_target;
	} table_row_t;

	typedef struct {
		logic [SLOT_W-1:0] slot;
		logic signed [VALUE_W-1:0] smoothed;
		logic signed [VALUE_W-1:0] target;
		logic last;
	} blend_result_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic mode;
	logic [SLOT_W-1:0] param_slot;
	logic [FIELD_W-1:0] setting_field;
	logic signed [VALUE_W-1:0] setting_value;
	logic [CAT_W-1:0] current_category;
	logic [CAT_W-1:0] previous_category;
	logic [15:0] transition_pct;
	logic [15:0] delta_time;
	logic out_valid;
	logic out_ready;
	logic [SLOT_W-1:0] out_slot;
	logic signed [VALUE_W-1:0] smoothed_value;
	logic signed [VALUE_W-1:0] blend_target;
	logic last_of_tick;
	logic cfg_valid;
	logic cfg_ready;
	logic [COUNT_W-1:0] cfg_data;

	logic signed [VALUE_W-1:0] cat_val [MAX_PARAMS][NUM_CATEGORIES];
	logic signed [VALUE_W-1:0] speed_of [MAX_PARAMS];
	logic signed [VALUE_W-1:0] lower_of [MAX_PARAMS];
	logic signed [VALUE_W-1:0] upper_of [MAX_PARAMS];
	bit smooth_of [MAX_PARAMS];
	bit signed [VALUE_W-1:0] running [MAX_PARAMS];
	bit filled [MAX_PARAMS][VALUES_PER_SLOT];
	logic [COUNT_W-1:0] active_count = '0;

	blend_result_t pending_results [$];
	int errors = 0;
	int calm_left [2] = '{0, 0};
	int phase_count [PHASES] = '{3, 7, 16, 31, 0, 1, 11};
	int phase_items [PHASES] = '{30, 45, 110, 40, 15, 15, 25};

	table_row_t stimulus_table [27] = '{
		'{ROW_WORD, '{MODE_TICK, 4'd0, 4'd0, 16'h0000, 4'd3, 4'd5, 16'h4000, 16'h1000},
			CHECK_NONE, 16'h0000, 16'h0000},
		'{ROW_WORD, '{MODE_WRITE, 4'd0, 4'd0, 16'h8000, 4'd0, 4'd0, 16'h0, 16'h0},
			CHECK_MODEL, 16'h0000, 16'h0000},
		'{ROW_WORD, '{MODE_WRITE, 4'd0, 4'd1, 16'h0100, 4'd0, 4'd0, 16'h0, 16'h0},
			CHECK_MODEL, 16'h0000, 16'h0000},
		'{ROW_WORD, '{MODE_WRITE, 4'd0, 4'd2, 16'hFE80, 4'd0, 4'd0, 16'h0, 16'h0},
			CHECK_MODEL, 16'h0000, 16'h0000},
		'{ROW_WORD, '{MODE_WRITE, 4'd0, 4'd3, 16'h7F00, 4'd0, 4'd0, 16'h0, 16'h0},
			CHECK_MODEL, 16'h0000, 16'h0000},
		'{ROW_WORD, '{MODE_WRITE, 4'd0, 4'd4, 16'h0000, 4'd0, 4'd0, 16'h0, 16'h0},
			CHECK_MODEL, 16'h0000, 16'h0000},
		'{ROW_WORD, '{MODE_WRITE, 4'd0, 4'd5, 16'h1234, 4'd0, 4'd0, 16'h0, 16'h0},
			CHECK_MODEL, 16'h0000, 16'h0000},
		'{ROW_WORD, '{MODE_WRITE, 4'd0, 4'd6, 16'hFFFF, 4'd0, 4'd0, 16'h0, 16'h0},
			CHECK_MODEL, 16'h0000, 16'h0000},
		'{ROW_WORD, '{MODE_WRITE, 4'd0, 4'd7, 16'h0040, 4'd0, 4'd0, 16'h0, 16'h0},
			CHECK_MODEL, 16'h0000, 16'h0000},
		'{ROW_WORD, '{MODE_WRITE, 4'd0, 4'd8, 16'h7FFF, 4'd0, 4'd0, 16'h0, 16'h0},
			CHECK_MODEL, 16'h0000, 16'h0000},
		'{ROW_WORD, '{MODE_WRITE, 4'd0, FIELD_SPEED, 16'h0100, 4'd0, 4'd0, 16'h0, 16'h0},
			CHECK_MODEL, 16'h0000, 16'h0000},
		'{ROW_WORD, '{MODE_WRITE, 4'd0, FIELD_LOWER, 16'h8000, 4'd0, 4'd0, 16'h0, 16'h0},
			CHECK_MODEL, 16'h0000, 16'h0000},
		'{ROW_WORD, '{MODE_WRITE, 4'd0, FIELD_UPPER, 16'h7FFF, 4'd0, 4'd0, 16'h0, 16'h0},
			CHECK_MODEL, 16'h0000, 16'h0000},
		'{ROW_WORD, '{MODE_WRITE, 4'd15, FIELD_UNUSED, 16'h7FFF, 4'd0, 4'd0, 16'h0, 16'h0},
			CHECK_MODEL, 16'h0000, 16'h0000},
		'{ROW_CFG, '{MODE_TICK, 4'd0, 4'd0, 16'd1, 4'd0, 4'd0, 16'h0, 16'h0},
			CHECK_MODEL, 16'h0000, 16'h0000},
		'{ROW_WORD, '{MODE_TICK, 4'd0, 4'd0, 16'h0000, 4'd8, 4'd0, 16'h8000, 16'hFFFF},
			CHECK_ONE, 16'h7FFF, 16'h7FFF},
		'{ROW_WORD, '{MODE_TICK, 4'd0, 4'd0, 16'h0000, 4'd8, 4'd0, 16'h0000, 16'hFFFF},
			CHECK_ONE, 16'h8000, 16'h8000},
		'{ROW_WORD, '{MODE_TICK, 4'd0, 4'd0, 16'h0000, 4'd8, 4'd0, 16'h8000, 16'h0000},
			CHECK_ONE, 16'h8000, 16'h7FFF},
		'{ROW_WORD, '{MODE_TICK, 4'd0, 4'd0, 16'h0000, 4'd15, 4'd9, 16'h8000, 16'hFFFF},
			CHECK_ONE, 16'h7FFF, 16'h7FFF},
		'{ROW_WORD, '{MODE_TICK, 4'd0, 4'd0, 16'h0000, 4'd5, 4'd2, 16'hFFFF, 16'h1234},
			CHECK_MODEL, 16'h0000, 16'h0000},
		'{ROW_WORD, '{MODE_WRITE, 4'd0, FIELD_SMOOTH, 16'hFFFF, 4'd0, 4'd0, 16'h0, 16'h0},
			CHECK_MODEL, 16'h0000, 16'h0000},
		'{ROW_WORD, '{MODE_TICK, 4'd0, 4'd0, 16'h0000, 4'd3, 4'd1, 16'h2000, 16'h3000},
			CHECK_MODEL, 16'h0000, 16'h0000},
		'{ROW_WORD, '{MODE_WRITE, 4'd0, FIELD_LOWER, 16'h4000, 4'd0, 4'd0, 16'h0, 16'h0},
			CHECK_MODEL, 16'h0000, 16'h0000},
		'{ROW_WORD, '{MODE_WRITE, 4'd0, FIELD_UPPER, 16'h1000, 4'd0, 4'd0, 16'h0, 16'h0},
			CHECK_MODEL, 16'h0000, 16'h0000},
		'{ROW_WORD, '{MODE_TICK, 4'd0, 4'd0, 16'h0000, 4'd8, 4'd0, 16'h8000, 16'hFFFF},
			CHECK_ONE, 16'h1000, 16'h7FFF},
		'{ROW_WORD, '{MODE_WRITE, 4'd0, FIELD_SPEED, 16'hFF00, 4'd0, 4'd0, 16'h0, 16'h0},
			CHECK_MODEL, 16'h0000, 16'h0000},
		'{ROW_WORD, '{MODE_TICK, 4'd0, 4'd0, 16'h0000, 4'd8, 4'd0, 16'h8000, 16'hFFFF},
			CHECK_ONE, 16'h1000, 16'h8000}
	};

	category_blend_smoother DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.param_slot(param_slot),
		.setting_field(setting_field),
		.setting_value(setting_value),
		.current_category(current_category),
		.previous_category(previous_category),
		.transition_pct(transition_pct),
		.delta_time(delta_time),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_slot(out_slot),
		.smoothed_value(smoothed_value),
		.blend_target(blend_target),
		.last_of_tick(last_of_tick),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic int draw_wait(input int side);
		if (calm_left[side] > 0) begin
			calm_left[side]--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0)
			calm_left[side] = $urandom_range(16, 40);
		return $urandom_range(0, 16);
	endfunction

	function automatic int first_gap(input int n);
		for (int s = 0; s < n; s++)
			for (int f = 0; f < VALUES_PER_SLOT; f++)
				if (!filled[s][f])
					return s * VALUES_PER_SLOT + f;
		return -1;
	endfunction

	// Blends, smooths and clamps every active slot for a tick; stores a setting for a write.
	task automatic apply_word(input in_word_t w, input bit keep);
		blend_result_t res;
		int n;
		int cc;
		int pc;
		longint pct, sp, t, sq, a, b, tgt, c, k;
		if (w.mode == MODE_WRITE) begin
			if (w.field < NUM_CATEGORIES)
				cat_val[w.slot][w.field] = w.value;
			else if (w.field == FIELD_SPEED)
				speed_of[w.slot] = w.value;
			else if (w.field == FIELD_LOWER)
				lower_of[w.slot] = w.value;
			else if (w.field == FIELD_UPPER)
				upper_of[w.slot] = w.value;
			else if (w.field == FIELD_SMOOTH)
				smooth_of[w.slot] = (w.value != '0);
			if (w.field < FIELD_SMOOTH)
				filled[w.slot][w.field] = 1'b1;
		end else begin
			cc = (w.cur >= NUM_CATEGORIES) ? NUM_CATEGORIES - 1 : w.cur;
			pc = (w.prev >= NUM_CATEGORIES) ? NUM_CATEGORIES - 1 : w.prev;
			pct = w.pct;
			k = w.dt;
			k = 2 * k;
			if (k > ONE_Q16)
				k = ONE_Q16;
			n = (active_count > MAX_PARAMS) ? MAX_PARAMS : active_count;
			for (int i = 0; i < n; i++) begin
				sp = speed_of[i];
				if (sp < 0)
					sp = 0;
				t = (pct * sp) >>> 8;
				if (t > ONE_Q15)
					t = ONE_Q15;
				if (smooth_of[i]) begin
					sq = (t * t) >>> 15;
					t = (sq * (3 * ONE_Q15 - 2 * t)) >>> 15;
				end
				a = cat_val[i][pc];
				b = cat_val[i][cc];
				tgt = a + (((b - a) * t) >>> 15);
				c = running[i];
				c = c + (((tgt - c) * k) >>> 16);
				if (c < lower_of[i])
					c = lower_of[i];
				if (c > upper_of[i])
					c = upper_of[i];
				running[i] = c[VALUE_W-1:0];
				if (keep) begin
					res.slot = SLOT_W'(i);
					res.smoothed = c[VALUE_W-1:0];
					res.target = tgt[VALUE_W-1:0];
					res.last = (i == n - 1);
					pending_results = {pending_results, res};
				end
			end
		end
	endtask

	// Until every slot that a tick would read is fully loaded, most words fill the next gap.
	function automatic in_word_t random_word();
		in_word_t w;
		int gap_at;
		int n;
		int r;
		int r2;
		n = (active_count > MAX_PARAMS) ? MAX_PARAMS : active_count;
		gap_at = first_gap(n);
		r = $urandom_range(0, 99);
		r2 = $urandom_range(0, 9);
		w.mode = MODE_WRITE;
		w.slot = SLOT_W'($urandom);
		w.field = FIELD_W'($urandom_range(0, FIELD_SMOOTH));
		w.value = VALUE_W'($urandom);
		w.cur = CAT_W'($urandom);
		w.prev = CAT_W'($urandom);
		w.pct = 16'($urandom);
		w.dt = 16'($urandom);
		if (gap_at >= 0 && r < 75) begin
			w.slot = SLOT_W'(gap_at / VALUES_PER_SLOT);
			w.field = FIELD_W'(gap_at % VALUES_PER_SLOT);
		end else if (r >= 90) begin
			w.field = FIELD_W'($urandom_range(FIELD_UNUSED, 15));
		end else if (gap_at < 0 && r < 45) begin
			w.mode = MODE_TICK;
			w.cur = CAT_W'(($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) :
				$urandom_range(0, 8));
			w.prev = CAT_W'(($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) :
				$urandom_range(0, 8));
			if (r2 < 6)
				w.pct = 16'($urandom_range(0, 32768));
			else if (r2 == 6)
				w.pct = 16'h8000;
			r2 = $urandom_range(0, 9);
			if (r2 < 6)
				w.dt = 16'($urandom_range(0, 8192));
			else if (r2 < 8)
				w.dt = 16'($urandom_range(8192, 32767));
		end
		if (w.mode == MODE_WRITE) begin
			if (w.field == FIELD_SPEED && r2 < 6)
				w.value = 16'($urandom_range(0, 1024));
			else if (w.field == FIELD_SPEED && r2 < 8)
				w.value = 16'(-int'($urandom_range(1, 32768)));
			else if (w.field == FIELD_LOWER && r2 < 7)
				w.value = 16'(-int'($urandom_range(0, 32768)));
			else if (w.field == FIELD_UPPER && r2 < 7)
				w.value = 16'($urandom_range(0, 32767));
			else if (w.field == FIELD_SMOOTH && r2 < 5)
				w.value = '0;
		end
		return w;
	endfunction

	task automatic send_word(input in_word_t w, input check_t how,
			input logic [VALUE_W-1:0] exp_smooth, input logic [VALUE_W-1:0] exp_target);
		blend_result_t res;
		int gap;
		gap = draw_wait(SIDE_SEND);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= w.mode;
		param_slot <= w.slot;
		setting_field <= w.field;
		setting_value <= w.value;
		current_category <= w.cur;
		previous_category <= w.prev;
		transition_pct <= w.pct;
		delta_time <= w.dt;
		do @(posedge clk); while (!in_ready);
		apply_word(w, how == CHECK_MODEL);
		if (how == CHECK_ONE) begin
			res.slot = '0;
			res.smoothed = exp_smooth;
			res.target = exp_target;
			res.last = 1'b1;
			pending_results = {pending_results, res};
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_active_count(input logic [COUNT_W-1:0] n);
		cfg_valid <= 1'b1;
		cfg_data <= n;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		active_count = n;
	endtask

	initial begin
		in_word_t w;
		int sent;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		mode <= MODE_TICK;
		param_slot <= '0;
		setting_field <= '0;
		setting_value <= '0;
		current_category <= '0;
		previous_category <= '0;
		transition_pct <= '0;
		delta_time <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (stimulus_table[i]) begin
			if (stimulus_table[i].kind == ROW_CFG) begin
				settle();
				write_active_count(stimulus_table[i].w.value[COUNT_W-1:0]);
			end else begin
				send_word(stimulus_table[i].w, stimulus_table[i].how,
					stimulus_table[i].exp_smooth, stimulus_table[i].exp_target);
			end
		end
		for (int p = 0; p < PHASES; p++) begin
			settle();
			write_active_count(COUNT_W'(phase_count[p]));
			sent = 0;
			while (sent < phase_items[p]) begin
				w = random_word();
				send_word(w, CHECK_MODEL, '0, '0);
				sent++;
			end
		end
		settle();
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		blend_result_t want;
		int stall;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = draw_wait(SIDE_TAKE);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected word: slot %0d value %0d target %0d", $time,
					out_slot, smoothed_value, blend_target);
			end else begin
				want = pending_results.pop_front();
				if (out_slot !== want.slot) begin
					errors++;
					$display("%0t: out_slot expected %0d, got %0d", $time, want.slot, out_slot);
				end
				if (smoothed_value !== want.smoothed) begin
					errors++;
					$display("%0t: smoothed_value expected %0d, got %0d", $time,
						want.smoothed, smoothed_value);
				end
				if (blend_target !== want.target) begin
					errors++;
					$display("%0t: blend_target expected %0d, got %0d", $time,
						want.target, blend_target);
				end
				if (last_of_tick !== want.last) begin
					errors++;
					$display("%0t: last_of_tick expected %0d, got %0d", $time,
						want.last, last_of_tick);
				end
			end
		end
	end

endmodule
